### hdl/trf_pkg.sv
// ----------------------------------------------------------------------------
// trf_pkg
// Constants for the transmit-request frame builder: frame bytes, byte
// positions within one frame and destination kinds.
// ----------------------------------------------------------------------------
package trf_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 255;
	localparam int unsigned POS_W           = 5;

	typedef logic [POS_W-1:0] pos_t;

	// byte positions within a frame
	localparam pos_t POS_DELIM     = 5'd0;
	localparam pos_t POS_LEN_HI    = 5'd1;
	localparam pos_t POS_LEN_LO    = 5'd2;
	localparam pos_t POS_TYPE      = 5'd3;
	localparam pos_t POS_ID        = 5'd4;
	localparam pos_t POS_DST_FIRST = 5'd5;
	localparam pos_t POS_DST_LAST  = 5'd12;
	localparam pos_t POS_RSV_HI    = 5'd13;
	localparam pos_t POS_RSV_LO    = 5'd14;
	localparam pos_t POS_RADIUS    = 5'd15;
	localparam pos_t POS_OPTIONS   = 5'd16;
	localparam pos_t POS_DATA      = 5'd17;
	localparam pos_t POS_CSUM      = 5'd18;

	localparam logic [7:0]  FRAME_DELIM  = 8'h7E;
	localparam logic [7:0]  TYPE_TX_REQ  = 8'h10;
	localparam logic [7:0]  FRAME_ID     = 8'h00;
	localparam logic [7:0]  RSV_HI       = 8'hFF;
	localparam logic [7:0]  RSV_LO       = 8'hFE;
	localparam logic [7:0]  RADIUS       = 8'h00;
	localparam logic [7:0]  OPTIONS      = 8'h00;
	localparam logic [7:0]  CSUM_BASE    = 8'hFF;
	localparam logic [15:0] HEADER_FIXED = 16'd14;
	localparam logic [7:0]  LEN_RESET    = 8'd30;

	localparam logic [63:0] ADDR_BCAST = 64'h0000_0000_0000_FFFF;
	localparam logic [63:0] ADDR_COORD = 64'h0;

	// destination kinds
	localparam logic [1:0] ACT_GIVEN = 2'd0;
	localparam logic [1:0] ACT_BCAST = 2'd1;

endpackage

### hdl/tx_request_framer_with_checksum.sv
// ----------------------------------------------------------------------------
// tx_request_framer_with_checksum
// Serializes message bytes into transmit-request frames with header and
// trailing checksum, one frame byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
// An accepted item is held in the sequencer stage (valid_s1), and each of its
//   frame bytes is then registered in the single output register.
// Throughput: one output byte per cycle while out_stall is low; the byte
//   sequencer takes a new item only as the last byte of the current one advances.
// Reset: arst_n clears the open frame, sum and both stages; payload_len
//   returns to 30.
module tx_request_framer_with_checksum #(
	parameter int unsigned MAX_PAYLOAD = trf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] dest_addr,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        end_of_frame,
	output logic        last_of_run
);

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	logic [7:0]         payload_len_q;
	logic [7:0]         bif_q, bif_d;
	logic [7:0]         sum_q, sum_d;
	trf_pkg::pos_t      idx_q, idx_d;
	logic               valid_s1, valid_s1_d;
	logic [1:0]         action_s1;
	logic [63:0]        dest_s1;
	logic [7:0]         data_s1;

	logic [7:0]         len_raw, len;
	logic [15:0]        total;
	logic [63:0]        addr;
	logic [2:0]         dst_sel;
	logic [7:0]         bif_inc;
	logic               close_frame;
	logic               advance, done, load, sum_en;
	logic [7:0]         byte_d;
	logic               eof_d, last_d;

	assign cfg_ready = 1'b1;

	always_comb begin
		len_raw = (payload_len_q == 8'd0) ? 8'd1 : payload_len_q;
		len     = (len_raw > MaxLen) ? MaxLen : len_raw;
		total   = {8'd0, len} + trf_pkg::HEADER_FIXED;
	end

	always_comb begin
		if (action_s1 == trf_pkg::ACT_GIVEN) begin
			addr = dest_s1;
		end else if (action_s1 == trf_pkg::ACT_BCAST) begin
			addr = trf_pkg::ADDR_BCAST;
		end else begin
			addr = trf_pkg::ADDR_COORD;
		end
	end

	assign dst_sel     = 3'(trf_pkg::POS_DST_LAST - idx_q);
	assign bif_inc     = bif_q + 8'd1;
	assign close_frame = (bif_inc >= len);

	always_comb begin
		byte_d = 8'd0;
		eof_d  = 1'b0;
		if (idx_q >= trf_pkg::POS_DST_FIRST && idx_q <= trf_pkg::POS_DST_LAST) begin
			byte_d = addr[{dst_sel, 3'b000} +: 8];
		end else begin
			unique case (idx_q)
				trf_pkg::POS_DELIM:   byte_d = trf_pkg::FRAME_DELIM;
				trf_pkg::POS_LEN_HI:  byte_d = total[15:8];
				trf_pkg::POS_LEN_LO:  byte_d = total[7:0];
				trf_pkg::POS_TYPE:    byte_d = trf_pkg::TYPE_TX_REQ;
				trf_pkg::POS_ID:      byte_d = trf_pkg::FRAME_ID;
				trf_pkg::POS_RSV_HI:  byte_d = trf_pkg::RSV_HI;
				trf_pkg::POS_RSV_LO:  byte_d = trf_pkg::RSV_LO;
				trf_pkg::POS_RADIUS:  byte_d = trf_pkg::RADIUS;
				trf_pkg::POS_OPTIONS: byte_d = trf_pkg::OPTIONS;
				trf_pkg::POS_DATA:    byte_d = data_s1;
				trf_pkg::POS_CSUM: begin
					byte_d = trf_pkg::CSUM_BASE - sum_q;
					eof_d  = 1'b1;
				end
				default:              byte_d = 8'd0;
			endcase
		end
	end

	assign sum_en  = (idx_q >= trf_pkg::POS_TYPE) && (idx_q <= trf_pkg::POS_DATA);
	assign last_d  = ((idx_q == trf_pkg::POS_DATA) && !close_frame) ||
	                 (idx_q == trf_pkg::POS_CSUM);
	assign advance = valid_s1 && (!out_valid || !out_stall);
	assign done    = advance && last_d;
	assign in_stall = valid_s1 && !done;
	assign load    = in_valid && !in_stall;

	always_comb begin
		bif_d      = bif_q;
		sum_d      = sum_q;
		idx_d      = idx_q;
		valid_s1_d = valid_s1;
		if (advance) begin
			if (idx_q == trf_pkg::POS_DATA) begin
				bif_d = bif_inc;
			end
			if (idx_q == trf_pkg::POS_CSUM) begin
				bif_d = 8'd0;
				sum_d = 8'd0;
			end else if (idx_q == trf_pkg::POS_DELIM) begin
				sum_d = 8'd0;
			end else if (sum_en) begin
				sum_d = sum_q + byte_d;
			end
			if (!last_d) begin
				idx_d = idx_q + trf_pkg::pos_t'(1);
			end
		end
		if (done) begin
			valid_s1_d = 1'b0;
		end
		if (load) begin
			valid_s1_d = 1'b1;
			idx_d      = (bif_d == 8'd0) ? trf_pkg::POS_DELIM : trf_pkg::POS_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_len_q <= trf_pkg::LEN_RESET;
			bif_q         <= 8'd0;
			sum_q         <= 8'd0;
			idx_q         <= trf_pkg::POS_DELIM;
			valid_s1      <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				payload_len_q <= cfg_data;
			end
			bif_q    <= bif_d;
			sum_q    <= sum_d;
			idx_q    <= idx_d;
			valid_s1 <= valid_s1_d;
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			action_s1 <= action;
			dest_s1   <= dest_addr;
			data_s1   <= data_byte;
		end
		if (advance) begin
			frame_byte   <= byte_d;
			end_of_frame <= eof_d;
			last_of_run  <= last_d;
		end
	end

`ifndef ASSERT_OFF
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && out_stall) |-> in_stall)
		else $error("input taken while sequencer blocked");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_frame) |-> last_of_run)
		else $error("checksum byte not last of run");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_q <= trf_pkg::POS_CSUM))
		else $error("byte position out of range");

	a_csum_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && idx_q == trf_pkg::POS_CSUM) |=> (bif_q == 8'd0 && sum_q == 8'd0))
		else $error("frame state not cleared after checksum");
`endif

endmodule

### bench/tb_tx_request_framer_with_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tx_request_framer_with_checksum
// Feeds message bytes under several payload lengths, rebuilds every frame
// byte (header, payload, checksum and the run flags) in a local model and
// compares each accepted output transaction against it, with random gaps
// on both channels.
// ----------------------------------------------------------------------------
module tb_tx_request_framer_with_checksum;

	localparam logic [1:0] ACT_COORD = 2'd2;
	localparam logic [1:0] ACT_UNDEF = 2'd3;
	localparam int         WD_LIMIT  = 2000;

	typedef struct {
		logic [1:0]  act;
		logic [63:0] dest;
		logic [7:0]  data;
	} msg_item_t;

	typedef struct {
		logic [7:0] fbyte;
		logic       eof;
		logic       last;
	} frame_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [63:0] dest_addr;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  frame_byte;
	logic        end_of_frame;
	logic        last_of_run;

	msg_item_t  msg_q[$];
	frame_out_t exp_bytes[$];

	logic [7:0] len_reg;
	logic [7:0] open_count;
	logic [7:0] csum_acc;

	bit  in_taken;
	bit  calm;
	int  err_count;
	int  wd_count;

	tx_request_framer_with_checksum uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.dest_addr    (dest_addr),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.end_of_frame (end_of_frame),
		.last_of_run  (last_of_run)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic void put_byte(logic [7:0] b, logic eof);
		frame_out_t r;
		r.fbyte = b;
		r.eof   = eof;
		r.last  = 1'b0;
		exp_bytes.push_back(r);
	endfunction

	function automatic void put_summed(logic [7:0] b);
		put_byte(b, 1'b0);
		csum_acc = csum_acc + b;
	endfunction

	// one accepted message byte -> its frame bytes
	function automatic void frame_predict(msg_item_t m);
		logic [7:0]  eff;
		logic [15:0] total;
		logic [63:0] addr;
		frame_out_t  tail;
		eff = (len_reg == 8'd0) ? 8'd1 : len_reg;
		if (eff > trf_pkg::MAX_PAYLOAD_DEF)
			eff = 8'(trf_pkg::MAX_PAYLOAD_DEF);
		if (open_count == 8'd0) begin
			total = {8'd0, eff} + trf_pkg::HEADER_FIXED;
			if (m.act == trf_pkg::ACT_GIVEN)
				addr = m.dest;
			else if (m.act == trf_pkg::ACT_BCAST)
				addr = trf_pkg::ADDR_BCAST;
			else
				addr = trf_pkg::ADDR_COORD;
			csum_acc = 8'd0;
			put_byte(trf_pkg::FRAME_DELIM, 1'b0);
			put_byte(total[15:8], 1'b0);
			put_byte(total[7:0], 1'b0);
			put_summed(trf_pkg::TYPE_TX_REQ);
			put_summed(trf_pkg::FRAME_ID);
			for (int i = 7; i >= 0; i--)
				put_summed(addr[i*8 +: 8]);
			put_summed(trf_pkg::RSV_HI);
			put_summed(trf_pkg::RSV_LO);
			put_summed(trf_pkg::RADIUS);
			put_summed(trf_pkg::OPTIONS);
		end
		put_summed(m.data);
		open_count = open_count + 8'd1;
		if (open_count >= eff) begin
			put_byte(trf_pkg::CSUM_BASE - csum_acc, 1'b1);
			open_count = 8'd0;
			csum_acc   = 8'd0;
		end
		tail = exp_bytes.pop_back();
		tail.last = 1'b1;
		exp_bytes.push_back(tail);
	endfunction

	// input side
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			msg_item_t m;
			m.act  = action;
			m.dest = dest_addr;
			m.data = data_byte;
			frame_predict(m);
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (msg_q.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
				msg_item_t m;
				m = msg_q.pop_front();
				action    <= m.act;
				dest_addr <= m.dest;
				data_byte <= m.data;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= !calm && ($urandom_range(0, 99) < 18);
	end

	// output side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (exp_bytes.size() == 0) begin
				report_mismatch("unexpected frame_byte", 64'(frame_byte), 64'd0);
			end else begin
				frame_out_t e;
				e = exp_bytes.pop_front();
				if (frame_byte !== e.fbyte)
					report_mismatch("frame_byte", 64'(frame_byte), 64'(e.fbyte));
				if (end_of_frame !== e.eof)
					report_mismatch("end_of_frame", 64'(end_of_frame), 64'(e.eof));
				if (last_of_run !== e.last)
					report_mismatch("last_of_run", 64'(last_of_run), 64'(e.last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			wd_count <= 0;
		else
			wd_count <= wd_count + 1;
		if (wd_count >= WD_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic wait_idle();
		while (msg_q.size() != 0 || in_valid || exp_bytes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_len(logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		len_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_msg(logic [1:0] a, logic [63:0] d, logic [7:0] b);
		msg_item_t m;
		m.act  = a;
		m.dest = d;
		m.data = b;
		msg_q.push_back(m);
	endfunction

	function automatic logic [63:0] rand_dest();
		case ($urandom_range(0, 5))
			0:       return 64'h0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		logic [7:0] lens[5];
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 8'd0;
		in_valid   = 1'b0;
		action     = trf_pkg::ACT_GIVEN;
		dest_addr  = 64'h0;
		data_byte  = 8'd0;
		out_stall  = 1'b0;
		in_taken   = 1'b0;
		calm       = 1'b0;
		err_count  = 0;
		wd_count   = 0;
		len_reg    = trf_pkg::LEN_RESET;
		open_count = 8'd0;
		csum_acc   = 8'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one-byte frames, all destination kinds
		write_len(8'd1);
		add_msg(trf_pkg::ACT_GIVEN, '1, 8'hFF);
		add_msg(trf_pkg::ACT_GIVEN, 64'h0, 8'h00);
		add_msg(trf_pkg::ACT_BCAST, 64'h0123_4567_89AB_CDEF, 8'hA5);
		add_msg(ACT_COORD, '1, 8'h5A);
		add_msg(ACT_UNDEF, '1, 8'h3C);
		add_msg(trf_pkg::ACT_GIVEN, 64'h0123_4567_89AB_CDEF, 8'h81);
		wait_idle();

		// zero length acts as one
		write_len(8'd0);
		add_msg(trf_pkg::ACT_GIVEN, 64'hFEDC_BA98_7654_3210, 8'h01);
		add_msg(trf_pkg::ACT_BCAST, 64'h0, 8'hFE);
		wait_idle();

		// longest length, frame left open, later bytes carry other actions
		write_len(8'd255);
		add_msg(trf_pkg::ACT_BCAST, 64'h0, 8'h11);
		add_msg(trf_pkg::ACT_GIVEN, '1, 8'h22);
		add_msg(ACT_UNDEF, 64'h0, 8'h33);
		add_msg(ACT_COORD, '1, 8'h44);
		wait_idle();

		// shrink below the count mid-frame
		write_len(8'd3);
		add_msg(trf_pkg::ACT_GIVEN, '1, 8'h55);
		add_msg(trf_pkg::ACT_GIVEN, 64'h8000_0000_0000_0001, 8'h66);
		wait_idle();

		write_len(8'd2);
		add_msg(trf_pkg::ACT_BCAST, '1, 8'h77);
		add_msg(ACT_UNDEF, '1, 8'h88);
		add_msg(trf_pkg::ACT_GIVEN, 64'h0, 8'h99);
		wait_idle();

		// random phases
		lens[0] = trf_pkg::LEN_RESET;
		lens[1] = 8'($urandom_range(2, 6));
		lens[2] = 8'd1;
		lens[3] = 8'($urandom_range(1, 12));
		lens[4] = 8'd255;
		for (int p = 0; p < 5; p++) begin
			calm = (p == 1);
			write_len(lens[p]);
			for (int k = 0; k < 20; k++)
				add_msg(2'($urandom_range(0, 3)), rand_dest(), 8'($urandom_range(0, 255)));
			wait_idle();
		end
		calm = 1'b0;

		repeat (20) @(posedge clk);
		if (exp_bytes.size() != 0)
			report_mismatch("frame bytes never seen", 64'(exp_bytes.size()), 64'd0);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
